>>> rtl/core/bbd_pkg.sv
// Shared types, constants and decode helpers for the banked bus decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package bbd_pkg;

    localparam int unsigned CmdW    = 2;
    localparam int unsigned AddrW   = 16;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned NibbleW = 4;
    localparam int unsigned LatchW  = 5;

    localparam int unsigned SInDataW  = 40;
    localparam int unsigned MOutDataW = 24;

    localparam int unsigned TileDepth    = 1024;
    localparam int unsigned ColorDepth   = 1024;
    localparam int unsigned ScratchDepth = 1008;
    localparam int unsigned SpriteDepth  = 16;
    localparam int unsigned VoiceDepth   = 32;
    localparam int unsigned XyDepth      = 16;
    localparam int unsigned ClearAddrW   = $clog2(TileDepth);

    localparam logic [AddrW-1:0] TrigMask    = 16'hFFF8;
    localparam logic [AddrW-1:0] TrigDecrypt = 16'h3FF8;
    localparam logic [AddrW-1:0] TrigPlainA  = 16'h3FF0;
    localparam logic [AddrW-1:0] TrigPlainB  = 16'h0038;
    localparam logic [AddrW-1:0] TrigPlainC  = 16'h03B0;
    localparam logic [AddrW-1:0] TrigPlainD  = 16'h1600;
    localparam logic [AddrW-1:0] TrigPlainE  = 16'h2120;
    localparam logic [AddrW-1:0] TrigPlainF  = 16'h8000;
    localparam logic [AddrW-1:0] TrigPlainG  = 16'h97F0;

    localparam logic [ByteW-1:0] OpenBusByte = 8'hBF;
    localparam logic [ByteW-1:0] FloatByte   = 8'hFF;
    localparam logic [ByteW-1:0] DipReset    = 8'hFF;

    localparam logic [2:0] LINE_IRQ   = 3'd0;
    localparam logic [2:0] LINE_SOUND = 3'd1;
    localparam logic [2:0] LINE_FLIP  = 3'd3;
    localparam logic [2:0] LINE_LOCK  = 3'd6;
    localparam logic [2:0] LINE_METER = 3'd7;

    typedef enum logic [CmdW-1:0] {
        CMD_MEM_RD = 2'd0,
        CMD_MEM_WR = 2'd1,
        CMD_IO_OUT = 2'd2,
        CMD_IO_IN  = 2'd3
    } bus_cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    typedef struct packed {
        logic hit;
        logic bank;
    } trig_t;

    function automatic trig_t trigger_lookup(input logic [AddrW-1:0] addr);
        trig_t            t;
        logic [AddrW-1:0] base;
        base   = addr & TrigMask;
        t.hit  = 1'b1;
        t.bank = 1'b0;
        if (base == TrigDecrypt) begin
            t.bank = 1'b1;
        end else if (base == TrigPlainA || base == TrigPlainB || base == TrigPlainC ||
                     base == TrigPlainD || base == TrigPlainE || base == TrigPlainF ||
                     base == TrigPlainG) begin
            t.bank = 1'b0;
        end else begin
            t.hit = 1'b0;
        end
        return t;
    endfunction

endpackage

>>> rtl/core/bbd_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies; instantiated by the datapath for the large stores.
module bbd_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bbd_ctrl.sv
// Controller state machine: clearing pass, item acceptance and result hand-off.
// Depends on bbd_pkg; drives the datapath through dp_cmd_t.
module bbd_ctrl
    import bbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        can_commit;

    assign can_commit = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd.clear_en = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear_en = 1'b1;
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EXEC: cmd.commit = can_commit;
            default: s_tready = 1'b0;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_EXEC))
        else $error("Accepted item did not enter execution.");

    a_commit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("Committed item produced no result.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("Result register overwritten before transfer.");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.clear_en) && !$past(status.clear_last) |-> !s_tready)
        else $error("Item accepted during clearing pass.");

endmodule

>>> rtl/core/bbd_datapath.sv
// Datapath: item capture, address decode, RAM and register stores, result register.
// Depends on bbd_pkg and bbd_ram; sequenced by bbd_ctrl through dp_cmd_t.
module bbd_datapath
    import bbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic [CmdW-1:0]      s_tuser,
    input  logic [SInDataW-1:0]  s_tdata,
    input  logic                 cfg_we,
    input  logic [ByteW-1:0]     cfg_data,
    output logic [MOutDataW-1:0] m_tdata
);

    bus_cmd_t              cmd_reg;
    logic [AddrW-1:0]      addr_reg;
    logic [ByteW-1:0]      wdata_reg, in0_reg, in1_reg;
    logic [ByteW-1:0]      dip_reg;
    logic [ClearAddrW-1:0] clr_cnt_reg;
    logic                  bank_reg, bank_next;
    logic [LatchW-1:0]     latch_reg, latch_next;
    logic [ByteW-1:0]      vector_reg, vector_next;
    logic [ByteW-1:0]      sprite_reg [SpriteDepth];
    logic [NibbleW-1:0]    voice_reg  [VoiceDepth];
    logic [ByteW-1:0]      xy_reg     [XyDepth];
    logic [MOutDataW-1:0]  out_reg;

    logic [ClearAddrW-1:0] ram_addr;
    logic [ByteW-1:0]      ram_wdata;
    logic [ByteW-1:0]      tile_rdata, color_rdata, scratch_rdata;
    logic                  tile_we, color_we, scratch_we;

    logic       is_mem, is_wr, ram_space, lo_page, hi_quad, sel_sprite, io_page;
    logic       wr_ram, wr_latch, wr_voice, wr_xy;
    trig_t      trig;
    logic [ByteW-1:0] ram_rd, rd_data;
    logic       rom_access;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg   <= bus_cmd_t'(s_tuser);
            addr_reg  <= s_tdata[15:0];
            wdata_reg <= s_tdata[23:16];
            in0_reg   <= s_tdata[31:24];
            in1_reg   <= s_tdata[39:32];
        end
        if (cmd.commit) begin
            out_reg <= {1'b0, vector_next, latch_next[4], latch_next[3], latch_next[2],
                        latch_next[1], latch_next[0], bank_next, rom_access, rd_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_reg     <= DipReset;
            clr_cnt_reg <= '0;
            bank_reg    <= 1'b0;
            latch_reg   <= '0;
            vector_reg  <= '0;
            for (int i = 0; i < SpriteDepth; i++) sprite_reg[i] <= '0;
            for (int i = 0; i < VoiceDepth; i++) voice_reg[i] <= '0;
            for (int i = 0; i < XyDepth; i++) xy_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                dip_reg <= cfg_data;
            end
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                bank_reg   <= bank_next;
                latch_reg  <= latch_next;
                vector_reg <= vector_next;
                if (wr_ram && sel_sprite) begin
                    sprite_reg[addr_reg[3:0]] <= wdata_reg;
                end
                if (wr_voice) begin
                    voice_reg[addr_reg[4:0]] <= wdata_reg[NibbleW-1:0];
                end
                if (wr_xy) begin
                    xy_reg[addr_reg[3:0]] <= wdata_reg;
                end
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == ClearAddrW'(TileDepth - 1));

    // Folded RAM/IO decode: bits 15 and 13 do not take part.
    assign is_mem     = (cmd_reg == CMD_MEM_RD) || (cmd_reg == CMD_MEM_WR);
    assign is_wr      = (cmd_reg == CMD_MEM_WR);
    assign ram_space  = addr_reg[14];
    assign lo_page    = !addr_reg[12];
    assign hi_quad    = lo_page && (addr_reg[11:10] == 2'b11);
    assign sel_sprite = hi_quad && (addr_reg[9:4] == 6'h3F);
    assign io_page    = addr_reg[12] && (addr_reg[11:8] == 4'h0);
    assign wr_ram     = is_wr && ram_space;
    assign wr_latch   = wr_ram && io_page && (addr_reg[7:3] == 5'b00000);
    assign wr_voice   = wr_ram && io_page && (addr_reg[7:5] == 3'b010);
    assign wr_xy      = wr_ram && io_page && (addr_reg[7:4] == 4'b0110);
    assign trig       = trigger_lookup(addr_reg);
    assign rom_access = (cmd_reg == CMD_MEM_RD) && !ram_space;

    assign tile_we    = cmd.clear_en ||
                        (cmd.commit && wr_ram && lo_page && addr_reg[11:10] == 2'b00);
    assign color_we   = cmd.clear_en ||
                        (cmd.commit && wr_ram && lo_page && addr_reg[11:10] == 2'b01);
    assign scratch_we = (cmd.clear_en && (clr_cnt_reg < ClearAddrW'(ScratchDepth))) ||
                        (cmd.commit && wr_ram && hi_quad && !sel_sprite);

    always_comb begin
        if (cmd.clear_en) begin
            ram_addr = clr_cnt_reg;
        end else if (cmd.accept) begin
            ram_addr = s_tdata[ClearAddrW-1:0];
        end else begin
            ram_addr = addr_reg[ClearAddrW-1:0];
        end
    end

    assign ram_wdata = cmd.clear_en ? '0 : wdata_reg;

    bbd_ram #(.Width(ByteW), .Depth(TileDepth)) u_tile_ram (
        .aclk(aclk), .we(tile_we), .re(cmd.accept), .addr(ram_addr),
        .wdata(ram_wdata), .rdata(tile_rdata)
    );

    bbd_ram #(.Width(ByteW), .Depth(ColorDepth)) u_color_ram (
        .aclk(aclk), .we(color_we), .re(cmd.accept), .addr(ram_addr),
        .wdata(ram_wdata), .rdata(color_rdata)
    );

    bbd_ram #(.Width(ByteW), .Depth(ScratchDepth)) u_scratch_ram (
        .aclk(aclk), .we(scratch_we), .re(cmd.accept),
        .addr(ram_addr[$clog2(ScratchDepth)-1:0]),
        .wdata(ram_wdata), .rdata(scratch_rdata)
    );

    always_comb begin
        ram_rd = FloatByte;
        if (lo_page) begin
            case (addr_reg[11:10])
                2'b00:   ram_rd = tile_rdata;
                2'b01:   ram_rd = color_rdata;
                2'b10:   ram_rd = OpenBusByte;
                default: ram_rd = sel_sprite ? sprite_reg[addr_reg[3:0]] : scratch_rdata;
            endcase
        end else if (io_page) begin
            case (addr_reg[7:6])
                2'b00:   ram_rd = in0_reg;
                2'b01:   ram_rd = in1_reg;
                2'b10:   ram_rd = dip_reg;
                default: ram_rd = FloatByte;
            endcase
        end
    end

    always_comb begin
        case (cmd_reg)
            CMD_MEM_RD: rd_data = ram_space ? ram_rd : '0;
            CMD_IO_IN:  rd_data = FloatByte;
            default:    rd_data = '0;
        endcase
    end

    always_comb begin
        bank_next = bank_reg;
        if (is_mem && !ram_space && trig.hit) begin
            bank_next = trig.bank;
        end
    end

    always_comb begin
        vector_next = vector_reg;
        if (cmd_reg == CMD_IO_OUT && addr_reg[7:0] == 8'h00) begin
            vector_next = wdata_reg;
        end
    end

    always_comb begin
        latch_next = latch_reg;
        if (wr_latch) begin
            case (addr_reg[2:0])
                LINE_IRQ:   latch_next[0] = wdata_reg[0];
                LINE_SOUND: latch_next[1] = wdata_reg[0];
                LINE_FLIP:  latch_next[2] = wdata_reg[0];
                LINE_LOCK:  latch_next[3] = wdata_reg[0];
                LINE_METER: latch_next[4] = wdata_reg[0];
                default:    latch_next = latch_reg;
            endcase
        end
    end

    assign m_tdata = out_reg;

    a_rom_read_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && rom_access |=> (out_reg[7:0] == 8'h00))
        else $error("ROM read returned a data byte.");

    a_bank_only_on_rom_space: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && ram_space |=> $stable(bank_reg))
        else $error("Bank switched on a RAM/IO access.");

    a_state_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(latch_reg) && $stable(vector_reg))
        else $error("Latch or vector changed without a commit.");

endmodule

>>> rtl/core/banked_bus_decoder_with_trigger_ranges.sv
// Top level of the banked bus decoder with trigger-range bank switching.
// Depends on bbd_pkg, bbd_ctrl, bbd_datapath and bbd_ram.
//
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    s_tuser command, s_tdata access fields
// m_       out        m_tvalid/m_tready    m_tdata result fields
// cfg_     in         cfg_valid/cfg_ready  cfg_data DIP switch byte
//
// An item is handled in ST_IDLE, which captures it and issues the RAM read, and
// then in ST_EXEC, which uses the registered RAM data and commits.
// After reset a clearing pass zeroes the tile, color and work RAMs; no item is accepted
// then, configuration writes are. A waiting result stalls only the commit of the next
// item, not its acceptance.
module banked_bus_decoder_with_trigger_ranges
    import bbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CmdW-1:0]      s_tuser,   // command
    input  logic [SInDataW-1:0]  s_tdata,   // address, write_data, player_inputs_0,
                                            // player_inputs_1
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [MOutDataW-1:0] m_tdata,   // read_data, rom_access, rom_bank, irq_enable,
                                            // sound_on, screen_flipped, coin_lock,
                                            // coin_meter, irq_vector, zero pad
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ByteW-1:0]     cfg_data   // dip_switch_bank
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    bbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    bbd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sim/bbd_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the banked bus decoder: a bus-access predictor and an in-order result check.
// Depends on bbd_pkg for the command enum, widths and decode constants.
package bbd_scoreboard_pkg;
    import bbd_pkg::*;

    typedef struct packed {
        logic             pad;
        logic [ByteW-1:0] vector;
        logic             meter;
        logic             lock;
        logic             flip;
        logic             sound;
        logic             irq;
        logic             bank;
        logic             rom;
        logic [ByteW-1:0] rdata;
    } bus_result_t;

    class bus_scoreboard;
        logic [ByteW-1:0]   dip;
        logic               bank;
        logic [ByteW-1:0]   tile_mem[TileDepth];
        logic [ByteW-1:0]   color_mem[ColorDepth];
        logic [ByteW-1:0]   work_mem[ScratchDepth];
        logic [ByteW-1:0]   sprite_mem[SpriteDepth];
        logic [NibbleW-1:0] voice_mem[VoiceDepth];
        logic [ByteW-1:0]   xy_mem[XyDepth];
        logic               irq, sound, flip, lock, meter;
        logic [ByteW-1:0]   vector;
        bus_result_t        expected_q[$];
        int                 errors;

        function new();
            dip    = DipReset;
            bank   = 1'b0;
            irq    = 1'b0;
            sound  = 1'b0;
            flip   = 1'b0;
            lock   = 1'b0;
            meter  = 1'b0;
            vector = '0;
            errors = 0;
            foreach (tile_mem[i]) tile_mem[i] = '0;
            foreach (color_mem[i]) color_mem[i] = '0;
            foreach (work_mem[i]) work_mem[i] = '0;
            foreach (sprite_mem[i]) sprite_mem[i] = '0;
            foreach (voice_mem[i]) voice_mem[i] = '0;
            foreach (xy_mem[i]) xy_mem[i] = '0;
        endfunction

        function void set_dip(logic [ByteW-1:0] value);
            dip = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function logic [ByteW-1:0] ram_fetch(logic [AddrW-1:0] a, logic [ByteW-1:0] in0,
                                             logic [ByteW-1:0] in1);
            if (a < 16'h4400) return tile_mem[a[9:0]];
            if (a < 16'h4800) return color_mem[a[9:0]];
            if (a < 16'h4C00) return OpenBusByte;
            if (a < 16'h4FF0) return work_mem[int'(a) - 'h4C00];
            if (a < 16'h5000) return sprite_mem[a[3:0]];
            if (a < 16'h5040) return in0;
            if (a < 16'h5080) return in1;
            if (a < 16'h50C0) return dip;
            return FloatByte;
        endfunction

        function void ram_store(logic [AddrW-1:0] a, logic [ByteW-1:0] d);
            if (a < 16'h4400) begin
                tile_mem[a[9:0]] = d;
            end else if (a < 16'h4800) begin
                color_mem[a[9:0]] = d;
            end else if (a < 16'h4C00) begin
                return;
            end else if (a < 16'h4FF0) begin
                work_mem[int'(a) - 'h4C00] = d;
            end else if (a < 16'h5000) begin
                sprite_mem[a[3:0]] = d;
            end else if (a <= 16'h5007) begin
                case (a[2:0])
                    LINE_IRQ:   irq   = d[0];
                    LINE_SOUND: sound = d[0];
                    LINE_FLIP:  flip  = d[0];
                    LINE_LOCK:  lock  = d[0];
                    LINE_METER: meter = d[0];
                    default: ;
                endcase
            end else if (a < 16'h5040) begin
                return;
            end else if (a <= 16'h505F) begin
                voice_mem[a[4:0]] = d[NibbleW-1:0];
            end else if (a <= 16'h506F) begin
                xy_mem[a[3:0]] = d;
            end
        endfunction

        function void note_access(bus_cmd_t cmd, logic [AddrW-1:0] addr, logic [ByteW-1:0] wd,
                                  logic [ByteW-1:0] in0, logic [ByteW-1:0] in1);
            bus_result_t      e;
            logic [AddrW-1:0] folded;
            e = '0;
            case (cmd)
                CMD_MEM_RD, CMD_MEM_WR: begin
                    if (!addr[14]) begin
                        case (addr & TrigMask)
                            TrigDecrypt: bank = 1'b1;
                            TrigPlainA, TrigPlainB, TrigPlainC, TrigPlainD,
                            TrigPlainE, TrigPlainF, TrigPlainG: bank = 1'b0;
                            default: ;
                        endcase
                        e.rom = (cmd == CMD_MEM_RD);
                    end else begin
                        folded = addr & 16'h5FFF;
                        if (cmd == CMD_MEM_RD) e.rdata = ram_fetch(folded, in0, in1);
                        else ram_store(folded, wd);
                    end
                end
                CMD_IO_OUT: begin
                    if (addr[7:0] == 8'h00) vector = wd;
                end
                default: e.rdata = FloatByte;
            endcase
            e.bank   = bank;
            e.irq    = irq;
            e.sound  = sound;
            e.flip   = flip;
            e.lock   = lock;
            e.meter  = meter;
            e.vector = vector;
            expected_q.push_back(e);
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic [MOutDataW-1:0] raw);
            bus_result_t e;
            bus_result_t got;
            if (expected_q.size() == 0) begin
                $error("result transfer %0h with no access outstanding", raw);
                errors++;
                return;
            end
            e   = expected_q.pop_front();
            got = bus_result_t'(raw);
            check_field("read_data", e.rdata, got.rdata);
            check_field("rom_access", e.rom, got.rom);
            check_field("rom_bank", e.bank, got.bank);
            check_field("irq_enable", e.irq, got.irq);
            check_field("sound_on", e.sound, got.sound);
            check_field("screen_flipped", e.flip, got.flip);
            check_field("coin_lock", e.lock, got.lock);
            check_field("coin_meter", e.meter, got.meter);
            check_field("irq_vector", e.vector, got.vector);
        endfunction
    endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for banked_bus_decoder_with_trigger_ranges: directed and random bus accesses
// with idling, back-pressure and DIP byte changes. Depends on bbd_pkg and bbd_scoreboard_pkg.
module tb_top;
    import bbd_pkg::*;
    import bbd_scoreboard_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CmdW-1:0]      s_tuser;
    logic [SInDataW-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [MOutDataW-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ByteW-1:0]     cfg_data;

    bus_scoreboard sb;
    bit            steady_mode;
    bit            hold_req;
    int            stall_left;

    banked_bus_decoder_with_trigger_ranges u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("[banked_bus_decoder_with_trigger_ranges] ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [AddrW-1:0] pick_address();
        int unsigned      base[11] = '{'h000, 'h400, 'h800, 'hC00, 'hFF0, 'h1000, 'h1008,
                                       'h1040, 'h1060, 'h1080, 'h10C0};
        int unsigned      span[11] = '{'h400, 'h400, 'h400, 'h3F0, 'h10, 'h8, 'h38,
                                       'h20, 'h10, 'h40, 'hF40};
        logic [AddrW-1:0] trig[8] = '{TrigDecrypt, TrigPlainA, TrigPlainB, TrigPlainC,
                                      TrigPlainD, TrigPlainE, TrigPlainF, TrigPlainG};
        logic [12:0]      off;
        int               r;
        int               k;
        r = $urandom_range(0, 99);
        if (r < 15) return trig[$urandom_range(0, 7)] | 16'($urandom_range(0, 7));
        if (r < 30) return {1'($urandom), 1'b0, 14'($urandom)};
        if (r < 40) return 16'($urandom);
        k = $urandom_range(0, 10);
        if (span[k] > 16 && $urandom_range(0, 1) == 0) off = 13'(base[k] + $urandom_range(0, 15));
        else off = 13'(base[k] + $urandom_range(0, span[k] - 1));
        return {1'($urandom), 1'b1, 1'($urandom), off};
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_access(bus_cmd_t'(s_tuser), s_tdata[15:0], s_tdata[23:16],
                               s_tdata[31:24], s_tdata[39:32]);
            end
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = 400;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (steady_mode || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            stall_left = idle_len() - 1;
        end
    end

    task automatic send_access(bus_cmd_t cmd, logic [AddrW-1:0] addr, logic [ByteW-1:0] wd);
        int gap;
        gap = (steady_mode || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {8'($urandom), 8'($urandom), wd, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_dip(logic [ByteW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_dip(value);
    endtask

    task automatic send_random();
        bus_cmd_t         cmd;
        logic [AddrW-1:0] addr;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 40) cmd = CMD_MEM_RD;
        else if (r < 75) cmd = CMD_MEM_WR;
        else if (r < 87) cmd = CMD_IO_OUT;
        else cmd = CMD_IO_IN;
        addr = pick_address();
        if (cmd == CMD_IO_OUT && $urandom_range(0, 9) < 4) addr[7:0] = 8'h00;
        send_access(cmd, addr, 8'($urandom));
    endtask

    initial begin
        logic [ByteW-1:0] dip_plan[6];
        sb          = new();
        steady_mode = 1'b0;
        hold_req    = 1'b0;
        stall_left  = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_MEM_RD;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_dip(8'h00);
        send_access(CMD_MEM_RD, 16'h0000, 8'h00);
        send_access(CMD_MEM_RD, 16'h3FF8, 8'h00);
        send_access(CMD_MEM_WR, 16'h0038, 8'h11);
        send_access(CMD_MEM_WR, 16'h3FFF, 8'hAA);
        send_access(CMD_MEM_RD, 16'h97F7, 8'h00);
        send_access(CMD_MEM_WR, 16'h4000, 8'hFF);
        send_access(CMD_MEM_RD, 16'hE000, 8'h00);
        send_access(CMD_MEM_WR, 16'h47FF, 8'h5A);
        send_access(CMD_MEM_RD, 16'h67FF, 8'h00);
        send_access(CMD_MEM_WR, 16'h4800, 8'h12);
        send_access(CMD_MEM_RD, 16'hCBFF, 8'h00);
        send_access(CMD_MEM_WR, 16'h4FEF, 8'h33);
        send_access(CMD_MEM_WR, 16'h4FFF, 8'h44);
        send_access(CMD_MEM_RD, 16'hEFFF, 8'h00);
        send_access(CMD_MEM_WR, 16'h5000, 8'h01);
        send_access(CMD_MEM_WR, 16'h7001, 8'hFF);
        send_access(CMD_MEM_WR, 16'h5003, 8'h01);
        send_access(CMD_MEM_WR, 16'hD006, 8'h01);
        send_access(CMD_MEM_WR, 16'h5007, 8'h01);
        send_access(CMD_MEM_WR, 16'h5000, 8'hFE);
        send_access(CMD_MEM_WR, 16'h505F, 8'hFF);
        send_access(CMD_MEM_WR, 16'h506F, 8'hC3);
        send_access(CMD_MEM_RD, 16'h5080, 8'h00);
        send_access(CMD_MEM_RD, 16'hFFFF, 8'h00);
        send_access(CMD_IO_OUT, 16'hFF00, 8'h7E);
        send_access(CMD_IO_OUT, 16'h0001, 8'h55);
        send_access(CMD_IO_IN, 16'h1234, 8'h00);

        dip_plan = '{8'hFF, 8'($urandom), 8'h01, 8'h80, 8'h7F, 8'($urandom)};
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_dip(dip_plan[phase]);
            steady_mode = (phase == 2);
            for (int n = 0; n < 300; n++) begin
                if (phase == 1 && n == 20) hold_req = 1'b1;
                if (phase == 4 && n == 150) drain();
                send_random();
            end
        end
        steady_mode = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[banked_bus_decoder_with_trigger_ranges] OK");
        end else begin
            $display("[banked_bus_decoder_with_trigger_ranges] ERROR");
        end
        $finish;
    end

endmodule
